// ----- design/lfps_pkg.sv -----
// ----------------------------------------------------------------------------
// lfps_pkg
// Shared widths, codes, types and the dodge phase tables of the line follower
// steering controller.
// ----------------------------------------------------------------------------
package lfps_pkg;

	localparam int LEVEL_BITS   = 10;
	localparam int SUM_BITS     = 24;
	localparam int DIST_BITS    = 9;
	localparam int GAIN_BITS    = 16;
	localparam int CFG_IDX_BITS = 3;
	localparam int CFG_DAT_BITS = 16;
	localparam int PHASE_BITS   = 4;
	localparam int TIME_BITS    = 10;

	localparam int ERR_BITS  = LEVEL_BITS + 1;
	localparam int DIFF_BITS = ERR_BITS + 1;
	localparam int PP_BITS   = GAIN_BITS + 1 + ERR_BITS;
	localparam int PD_BITS   = GAIN_BITS + 1 + DIFF_BITS;
	localparam int PI_BITS   = GAIN_BITS + 1 + SUM_BITS;
	localparam int ACC_BITS  = PI_BITS + 2;

	localparam logic [PHASE_BITS-1:0] PHASE_COUNT = PHASE_BITS'(9);

	localparam logic [CFG_IDX_BITS-1:0] REG_LINE_THR        = CFG_IDX_BITS'(0);
	localparam logic [CFG_IDX_BITS-1:0] REG_OBSTACLE_LIMIT  = CFG_IDX_BITS'(1);
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_P          = CFG_IDX_BITS'(2);
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_I          = CFG_IDX_BITS'(3);
	localparam logic [CFG_IDX_BITS-1:0] REG_GAIN_D          = CFG_IDX_BITS'(4);

	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_TICK   = 1'b1;

	typedef enum logic [1:0] {
		DRV_STOP  = 2'd0,
		DRV_FWD   = 2'd1,
		DRV_LEFT  = 2'd2,
		DRV_RIGHT = 2'd3
	} drive_t;

	typedef enum logic [1:0] {
		CMD_KEEP = 2'd0,
		CMD_SET  = 2'd1,
		CMD_PID  = 2'd2
	} cmd_t;

	typedef struct packed {
		logic [LEVEL_BITS-1:0] line_thr;
		logic [DIST_BITS-1:0]  obstacle_limit;
		logic [GAIN_BITS-1:0]  gain_p;
		logic [GAIN_BITS-1:0]  gain_i;
		logic [GAIN_BITS-1:0]  gain_d;
	} cfg_t;

	// Second stage: drive command plus the three PID products
	typedef struct packed {
		logic                      valid;
		cmd_t                      cmd;
		drive_t                    set_drive;
		logic                      dodging;
		logic signed [PP_BITS-1:0] prod_p;
		logic signed [PD_BITS-1:0] prod_d;
		logic signed [PI_BITS-1:0] prod_i;
	} stage2_t;

	function automatic drive_t phase_drive(input logic [PHASE_BITS-1:0] ph);
		drive_t r;
		case (ph)
			4'd0:    r = DRV_STOP;
			4'd1:    r = DRV_RIGHT;
			4'd2:    r = DRV_STOP;
			4'd3:    r = DRV_FWD;
			4'd4:    r = DRV_STOP;
			4'd5:    r = DRV_LEFT;
			4'd6:    r = DRV_STOP;
			4'd7:    r = DRV_FWD;
			4'd8:    r = DRV_RIGHT;
			default: r = DRV_STOP;
		endcase
		return r;
	endfunction

	function automatic logic [TIME_BITS-1:0] phase_len(input logic [PHASE_BITS-1:0] ph);
		logic [TIME_BITS-1:0] r;
		case (ph)
			4'd1, 4'd8: r = TIME_BITS'(200);
			4'd5:       r = TIME_BITS'(400);
			4'd7:       r = TIME_BITS'(440);
			default:    r = TIME_BITS'(500);
		endcase
		return r;
	endfunction

endpackage

// ----- design/lfps_sample_if.sv -----
// ----------------------------------------------------------------------------
// lfps_sample_if
// Input request channel: opcode, reflectance levels and obstacle distance.
// ----------------------------------------------------------------------------
interface lfps_sample_if
	import lfps_pkg::*;
();
	logic                  valid;
	logic                  ready;
	logic                  opcode;
	logic [LEVEL_BITS-1:0] left_level;
	logic [LEVEL_BITS-1:0] right_level;
	logic [DIST_BITS-1:0]  distance_cm;

	modport source (output valid, opcode, left_level, right_level, distance_cm,
		input ready);
	modport sink (input valid, opcode, left_level, right_level, distance_cm,
		output ready);
endinterface

// ----- design/lfps_drive_if.sv -----
// ----------------------------------------------------------------------------
// lfps_drive_if
// Result channel: drive mode, motor enables and dodge flag.
// ----------------------------------------------------------------------------
interface lfps_drive_if;
	logic       valid;
	logic       ready;
	logic [1:0] drive_mode;
	logic       motor_left;
	logic       motor_right;
	logic       dodging;

	modport source (output valid, drive_mode, motor_left, motor_right, dodging,
		input ready);
	modport sink (input valid, drive_mode, motor_left, motor_right, dodging,
		output ready);
endinterface

// ----- design/lfps_cfg_if.sv -----
// ----------------------------------------------------------------------------
// lfps_cfg_if
// Configuration write channel: register index and write data.
// ----------------------------------------------------------------------------
interface lfps_cfg_if
	import lfps_pkg::*;
();
	logic                    valid;
	logic                    ready;
	logic [CFG_IDX_BITS-1:0] index;
	logic [CFG_DAT_BITS-1:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

// ----- design/line_follower_pid_steering.sv -----
// ----------------------------------------------------------------------------
// line_follower_pid_steering
// Request path: input register, then state update and products, then sign
// and drive into the result register. Throughput: one request per cycle
// unless drive.ready stalls; the three PID products are the deepest path.
// Reset: asynchronous; clears PID state, dodge sequence, drive to stop and
// restores configuration register defaults.
// ----------------------------------------------------------------------------
module line_follower_pid_steering
	import lfps_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	lfps_cfg_if.sink     cfg,
	lfps_sample_if.sink  sample,
	lfps_drive_if.source drive
);
	cfg_t    regs;
	stage2_t s2;
	logic    back_ready;

	lfps_cfg_regs u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	lfps_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.sample     (sample),
		.regs       (regs),
		.next_ready (back_ready),
		.s2         (s2)
	);

	lfps_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.s2     (s2),
		.ready  (back_ready),
		.drive  (drive)
	);
endmodule

// ----- design/lfps_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// lfps_cfg_regs
// Configuration register file; writes beyond the last register are dropped.
// ----------------------------------------------------------------------------
module lfps_cfg_regs
	import lfps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lfps_cfg_if.sink   cfg,
	output cfg_t       regs
);
	cfg_t regs_q;

	assign cfg.ready = 1'b1;
	assign regs = regs_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			regs_q.line_thr        <= LEVEL_BITS'(600);
			regs_q.obstacle_limit  <= DIST_BITS'(25);
			regs_q.gain_p          <= GAIN_BITS'(4096);
			regs_q.gain_i          <= GAIN_BITS'(410);
			regs_q.gain_d          <= GAIN_BITS'(41);
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_LINE_THR:        regs_q.line_thr        <= cfg.data[LEVEL_BITS-1:0];
				REG_OBSTACLE_LIMIT:  regs_q.obstacle_limit  <= cfg.data[DIST_BITS-1:0];
				REG_GAIN_P:          regs_q.gain_p          <= cfg.data[GAIN_BITS-1:0];
				REG_GAIN_I:          regs_q.gain_i          <= cfg.data[GAIN_BITS-1:0];
				REG_GAIN_D:          regs_q.gain_d          <= cfg.data[GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end
endmodule

// ----- design/lfps_front.sv -----
// ----------------------------------------------------------------------------
// lfps_front
// Input register, PID state update, dodge sequencer and the PID products.
// ----------------------------------------------------------------------------
module lfps_front
	import lfps_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	lfps_sample_if.sink sample,
	input  cfg_t       regs,
	input  logic       next_ready,
	output stage2_t    s2
);
	logic                  valid_s1;
	logic                  opcode_s1;
	logic [LEVEL_BITS-1:0] left_s1;
	logic [LEVEL_BITS-1:0] right_s1;
	logic [DIST_BITS-1:0]  dist_s1;

	logic signed [SUM_BITS-1:0] error_sum_q;
	logic signed [ERR_BITS-1:0] last_error_q;
	logic                       dodge_active_q;
	logic [PHASE_BITS-1:0]      dodge_phase_q;
	logic [TIME_BITS-1:0]       phase_time_q;
	stage2_t                    s2_q;

	logic ready_s2, ready_s1, adv_s1;

	logic signed [ERR_BITS-1:0]  err;
	logic signed [DIFF_BITS-1:0] diff;
	logic signed [SUM_BITS:0]    sum_ext;
	logic signed [SUM_BITS-1:0]  sum_sat;
	logic signed [GAIN_BITS:0]   gp, gi, gd;
	logic                        left_black, right_black;
	logic [TIME_BITS-1:0]        time_inc;
	logic [PHASE_BITS-1:0]       phase_inc;

	logic                  pid_step;
	logic                  nx_active;
	logic [PHASE_BITS-1:0] nx_phase;
	logic [TIME_BITS-1:0]  nx_time;
	cmd_t                  nx_cmd;
	drive_t                nx_drive;

	assign ready_s2     = !s2_q.valid || next_ready;
	assign ready_s1     = !valid_s1 || ready_s2;
	assign adv_s1       = valid_s1 && ready_s2;
	assign sample.ready = ready_s1;
	assign s2           = s2_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (ready_s1 && sample.valid) begin
			opcode_s1 <= sample.opcode;
			left_s1   <= sample.left_level;
			right_s1  <= sample.right_level;
			dist_s1   <= sample.distance_cm;
		end
	end

	always_comb begin
		err     = signed'({1'b0, right_s1}) - signed'({1'b0, left_s1});
		diff    = DIFF_BITS'(err) - DIFF_BITS'(last_error_q);
		sum_ext = (SUM_BITS+1)'(error_sum_q) + (SUM_BITS+1)'(err);
		// clamp on overflow of the running sum
		if (sum_ext[SUM_BITS] != sum_ext[SUM_BITS-1]) begin
			sum_sat = {sum_ext[SUM_BITS], {(SUM_BITS-1){!sum_ext[SUM_BITS]}}};
		end else begin
			sum_sat = sum_ext[SUM_BITS-1:0];
		end
		gp = signed'({1'b0, regs.gain_p});
		gi = signed'({1'b0, regs.gain_i});
		gd = signed'({1'b0, regs.gain_d});

		left_black  = left_s1 > regs.line_thr;
		right_black = right_s1 > regs.line_thr;
		time_inc    = phase_time_q + TIME_BITS'(1);
		phase_inc   = dodge_phase_q + PHASE_BITS'(1);

		pid_step  = 1'b0;
		nx_active = dodge_active_q;
		nx_phase  = dodge_phase_q;
		nx_time   = phase_time_q;
		nx_cmd    = CMD_KEEP;
		nx_drive  = DRV_STOP;

		if (opcode_s1 == OP_TICK) begin
			if (dodge_active_q) begin
				if (dodge_phase_q >= PHASE_COUNT) begin
					nx_active = 1'b0;
					nx_phase  = '0;
					nx_time   = '0;
				end else if (time_inc >= phase_len(dodge_phase_q)) begin
					nx_time = '0;
					if (phase_inc >= PHASE_COUNT) begin
						// last phase done: drive stays as it is
						nx_active = 1'b0;
						nx_phase  = '0;
					end else begin
						nx_phase = phase_inc;
						nx_cmd   = CMD_SET;
						nx_drive = phase_drive(phase_inc);
					end
				end else begin
					nx_time = time_inc;
				end
			end
		end else if (!dodge_active_q) begin
			pid_step = 1'b1;
			if (dist_s1 <= regs.obstacle_limit) begin
				nx_active = 1'b1;
				nx_phase  = '0;
				nx_time   = '0;
				nx_cmd    = CMD_SET;
				nx_drive  = phase_drive('0);
			end else if (left_black && right_black) begin
				nx_cmd = CMD_PID;
			end else if (left_black) begin
				nx_cmd   = CMD_SET;
				nx_drive = DRV_LEFT;
			end else if (right_black) begin
				nx_cmd   = CMD_SET;
				nx_drive = DRV_RIGHT;
			end else begin
				nx_cmd   = CMD_SET;
				nx_drive = DRV_FWD;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			error_sum_q    <= '0;
			last_error_q   <= '0;
			dodge_active_q <= 1'b0;
			dodge_phase_q  <= '0;
			phase_time_q   <= '0;
			s2_q.valid     <= 1'b0;
			s2_q.cmd       <= CMD_KEEP;
			s2_q.set_drive <= DRV_STOP;
			s2_q.dodging   <= 1'b0;
			s2_q.prod_p    <= '0;
			s2_q.prod_d    <= '0;
			s2_q.prod_i    <= '0;
		end else begin
			if (ready_s2) begin
				s2_q.valid <= adv_s1;
			end
			if (adv_s1) begin
				if (pid_step) begin
					error_sum_q  <= sum_sat;
					last_error_q <= err;
				end
				dodge_active_q <= nx_active;
				dodge_phase_q  <= nx_phase;
				phase_time_q   <= nx_time;
				s2_q.cmd       <= nx_cmd;
				s2_q.set_drive <= nx_drive;
				s2_q.dodging   <= nx_active;
				s2_q.prod_p    <= PP_BITS'(gp) * PP_BITS'(err);
				s2_q.prod_d    <= PD_BITS'(gd) * PD_BITS'(diff);
				s2_q.prod_i    <= PI_BITS'(gi) * PI_BITS'(sum_sat);
			end
		end
	end
endmodule

// ----- design/lfps_back.sv -----
// ----------------------------------------------------------------------------
// lfps_back
// PID sign, drive resolution and the result register.
// ----------------------------------------------------------------------------
module lfps_back
	import lfps_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  stage2_t     s2,
	output logic        ready,
	lfps_drive_if.source drive
);
	drive_t                      drive_q;
	logic                        dodging_q;
	logic                        valid_q;
	logic                        adv;
	logic signed [ACC_BITS-1:0]  acc;
	drive_t                      nx_drive;

	assign ready = !valid_q || drive.ready;
	assign adv   = s2.valid && ready;

	always_comb begin
		acc = ACC_BITS'(s2.prod_p) + ACC_BITS'(s2.prod_d) + ACC_BITS'(s2.prod_i);
		case (s2.cmd)
			CMD_SET: nx_drive = s2.set_drive;
			CMD_PID: begin
				if (acc == '0) begin
					nx_drive = DRV_FWD;
				end else if (acc[ACC_BITS-1]) begin
					nx_drive = DRV_LEFT;
				end else begin
					nx_drive = DRV_RIGHT;
				end
			end
			default: nx_drive = drive_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q   <= 1'b0;
			drive_q   <= DRV_STOP;
			dodging_q <= 1'b0;
		end else begin
			if (ready) begin
				valid_q <= s2.valid;
			end
			if (adv) begin
				drive_q   <= nx_drive;
				dodging_q <= s2.dodging;
			end
		end
	end

	assign drive.valid       = valid_q;
	assign drive.drive_mode  = drive_q;
	assign drive.motor_left  = (drive_q == DRV_FWD) || (drive_q == DRV_RIGHT);
	assign drive.motor_right = (drive_q == DRV_FWD) || (drive_q == DRV_LEFT);
	assign drive.dodging     = dodging_q;
endmodule

// ----- tb/sv/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the line follower steering controller. Sensor
// samples and millisecond ticks are queued per configuration phase and fed
// with random gaps. Each accepted request updates a local steering model that
// predicts the drive result. The result channel is stalled at random and each
// result is checked field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb;
	import lfps_pkg::*;

	localparam int LEVEL_MAX    = (1 << LEVEL_BITS) - 1;
	localparam int DIST_MAX     = (1 << DIST_BITS) - 1;
	localparam int DODGE_PHASES = 9;
	localparam int DODGE_TICKS  = 3740;
	localparam longint SUM_MAX  = (longint'(1) <<< (SUM_BITS - 1)) - 1;
	localparam longint SUM_MIN  = -SUM_MAX - 1;

	typedef struct packed {
		logic                  hold;
		logic                  opcode;
		logic [LEVEL_BITS-1:0] left_level;
		logic [LEVEL_BITS-1:0] right_level;
		logic [DIST_BITS-1:0]  distance_cm;
	} steer_req_t;

	typedef struct packed {
		drive_t mode;
		logic   motor_left;
		logic   motor_right;
		logic   dodging;
	} drive_res_t;

	typedef struct packed {
		drive_t               drv;
		logic [TIME_BITS-1:0] ticks;
	} leg_t;

	logic clk;
	logic arst_n;

	lfps_cfg_if    cfg ();
	lfps_sample_if sample ();
	lfps_drive_if  drive ();

	line_follower_pid_steering dut (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.sample (sample),
		.drive  (drive)
	);

	// shadow configuration
	logic [LEVEL_BITS-1:0] thr_r;
	logic [DIST_BITS-1:0]  lim_r;
	logic [GAIN_BITS-1:0]  gp_r;
	logic [GAIN_BITS-1:0]  gi_r;
	logic [GAIN_BITS-1:0]  gd_r;

	// steering model state
	logic signed [SUM_BITS-1:0] err_sum;
	logic signed [ERR_BITS-1:0] last_err;
	logic                       dodge_on;
	int unsigned                dodge_ph;
	logic [TIME_BITS-1:0]       ph_time;
	drive_t                     drive_now;

	steer_req_t  pend_q[$];
	drive_res_t  drive_expect_q[$];
	int unsigned fail_cnt;
	int unsigned gen_dodge_left;
	int unsigned dodge_budget;
	logic        hold_next;
	logic        in_acc;
	int unsigned feed_gap;
	int unsigned stall_left;
	logic        calm;
	int unsigned calm_left;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	function automatic leg_t dodge_leg(input int unsigned ph);
		leg_t l;
		case (ph)
			0:       l = '{DRV_STOP,  TIME_BITS'(500)};
			1:       l = '{DRV_RIGHT, TIME_BITS'(200)};
			2:       l = '{DRV_STOP,  TIME_BITS'(500)};
			3:       l = '{DRV_FWD,   TIME_BITS'(500)};
			4:       l = '{DRV_STOP,  TIME_BITS'(500)};
			5:       l = '{DRV_LEFT,  TIME_BITS'(400)};
			6:       l = '{DRV_STOP,  TIME_BITS'(500)};
			7:       l = '{DRV_FWD,   TIME_BITS'(440)};
			default: l = '{DRV_RIGHT, TIME_BITS'(200)};
		endcase
		return l;
	endfunction

	function automatic drive_res_t steer_step(input logic op,
			input logic [LEVEL_BITS-1:0] lv, input logic [LEVEL_BITS-1:0] rv,
			input logic [DIST_BITS-1:0] dist_cm);
		drive_res_t r;
		leg_t       leg;
		int         e;
		longint     s;
		longint     ctl;
		logic       lb;
		logic       rb;
		if (op == OP_TICK) begin
			if (dodge_on) begin
				if (dodge_ph >= DODGE_PHASES) begin
					dodge_on = 1'b0;
					dodge_ph = 0;
					ph_time  = '0;
				end else begin
					ph_time = ph_time + 1'b1;
					leg = dodge_leg(dodge_ph);
					if (ph_time >= leg.ticks) begin
						ph_time = '0;
						dodge_ph++;
						if (dodge_ph >= DODGE_PHASES) begin
							// drive stays as the last leg left it
							dodge_on = 1'b0;
							dodge_ph = 0;
						end else begin
							leg = dodge_leg(dodge_ph);
							drive_now = leg.drv;
						end
					end
				end
			end
		end else if (!dodge_on) begin
			lb = lv > thr_r;
			rb = rv > thr_r;
			e = int'(rv) - int'(lv);
			s = longint'(err_sum) + e;
			if (s > SUM_MAX)
				s = SUM_MAX;
			if (s < SUM_MIN)
				s = SUM_MIN;
			// exact Q12 control value, only its sign matters
			ctl = longint'(gp_r) * e + longint'(gd_r) * (e - int'(last_err))
				+ longint'(gi_r) * s;
			err_sum  = SUM_BITS'(s);
			last_err = ERR_BITS'(e);
			if (dist_cm <= lim_r) begin
				dodge_on = 1'b1;
				dodge_ph = 0;
				ph_time  = '0;
				leg = dodge_leg(0);
				drive_now = leg.drv;
			end else if (lb && rb) begin
				if (ctl > 0)
					drive_now = DRV_RIGHT;
				else if (ctl < 0)
					drive_now = DRV_LEFT;
				else
					drive_now = DRV_FWD;
			end else if (lb) begin
				drive_now = DRV_LEFT;
			end else if (rb) begin
				drive_now = DRV_RIGHT;
			end else begin
				drive_now = DRV_FWD;
			end
		end
		r.mode        = drive_now;
		r.motor_left  = (drive_now == DRV_FWD) || (drive_now == DRV_RIGHT);
		r.motor_right = (drive_now == DRV_FWD) || (drive_now == DRV_LEFT);
		r.dodging     = dodge_on;
		return r;
	endfunction

	function automatic int unsigned pick_gap();
		int unsigned r;
		r = $urandom_range(99);
		if (calm || r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(3, 1);
		if (r < 98)
			return $urandom_range(10, 4);
		return $urandom_range(40, 11);
	endfunction

	function automatic logic [LEVEL_BITS-1:0] pick_level();
		int unsigned r;
		int          v;
		r = $urandom_range(9);
		case (r)
			0:       v = 0;
			1:       v = LEVEL_MAX;
			2, 3:    v = int'(thr_r) + int'($urandom_range(6)) - 3;
			4, 5, 6: v = $urandom_range(LEVEL_MAX, thr_r);
			default: v = $urandom_range(LEVEL_MAX);
		endcase
		if (v < 0)
			v = 0;
		if (v > LEVEL_MAX)
			v = LEVEL_MAX;
		return LEVEL_BITS'(v);
	endfunction

	task automatic push_sample(input int l, input int r, input int d);
		steer_req_t rq;
		rq.hold        = hold_next;
		rq.opcode      = OP_SAMPLE;
		rq.left_level  = LEVEL_BITS'(l);
		rq.right_level = LEVEL_BITS'(r);
		rq.distance_cm = DIST_BITS'(d);
		hold_next = 1'b0;
		if (gen_dodge_left == 0 && rq.distance_cm <= lim_r)
			gen_dodge_left = DODGE_TICKS;
		pend_q.push_back(rq);
	endtask

	task automatic push_tick();
		steer_req_t rq;
		rq.hold        = hold_next;
		rq.opcode      = OP_TICK;
		rq.left_level  = LEVEL_BITS'($urandom);
		rq.right_level = LEVEL_BITS'($urandom);
		rq.distance_cm = DIST_BITS'($urandom);
		hold_next = 1'b0;
		if (gen_dodge_left != 0)
			gen_dodge_left--;
		pend_q.push_back(rq);
	endtask

	// mostly ticks, with the odd sample that the dodge must ignore
	task automatic dodge_item();
		if ($urandom_range(9) == 0)
			push_sample($urandom_range(LEVEL_MAX), $urandom_range(LEVEL_MAX),
				$urandom_range(DIST_MAX));
		else
			push_tick();
	endtask

	task automatic run_random(input int unsigned n_items);
		int unsigned made;
		int unsigned r;
		made = 0;
		while (made < n_items) begin
			if ($urandom_range(99) == 0)
				hold_next = 1'b1;
			if (gen_dodge_left != 0) begin
				dodge_item();
			end else begin
				r = $urandom_range(99);
				if (r < 10 || lim_r == DIST_MAX) begin
					push_tick();
				end else if (r < 12 && dodge_budget != 0) begin
					dodge_budget--;
					push_sample(pick_level(), pick_level(), $urandom_range(lim_r));
				end else if (r < 30) begin
					push_sample(pick_level(), pick_level(), lim_r + 1);
				end else begin
					push_sample(pick_level(), pick_level(),
						$urandom_range(DIST_MAX, lim_r + 1));
				end
				made++;
			end
		end
	endtask

	task automatic wait_idle();
		while (pend_q.size() != 0 || sample.valid || drive_expect_q.size() != 0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic cfg_write(input logic [CFG_IDX_BITS-1:0] idx,
			input logic [CFG_DAT_BITS-1:0] val);
		@(negedge clk);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data  <= val;
		@(posedge clk);
		while (!cfg.ready)
			@(posedge clk);
		case (idx)
			REG_LINE_THR:        thr_r = val[LEVEL_BITS-1:0];
			REG_OBSTACLE_LIMIT:  lim_r = val[DIST_BITS-1:0];
			REG_GAIN_P:          gp_r  = val[GAIN_BITS-1:0];
			REG_GAIN_I:          gi_r  = val[GAIN_BITS-1:0];
			REG_GAIN_D:          gd_r  = val[GAIN_BITS-1:0];
			default:             ;
		endcase
	endtask

	task automatic apply_settings(input int thr, input int lim, input int gp,
			input int gi, input int gd);
		wait_idle();
		cfg_write(REG_LINE_THR, CFG_DAT_BITS'(thr));
		cfg_write(REG_OBSTACLE_LIMIT, CFG_DAT_BITS'(lim));
		cfg_write(REG_GAIN_P, CFG_DAT_BITS'(gp));
		cfg_write(REG_GAIN_I, CFG_DAT_BITS'(gi));
		cfg_write(REG_GAIN_D, CFG_DAT_BITS'(gd));
		// unused index, must change nothing
		cfg_write(CFG_IDX_BITS'($urandom_range(7, 5)), CFG_DAT_BITS'($urandom));
		@(negedge clk);
		cfg.valid <= 1'b0;
	endtask

	task automatic check_field(input string name, input int want, input int got);
		if (want != got) begin
			fail_cnt++;
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
		end
	endtask

	// record accepted requests and predict their results
	always @(posedge clk) begin
		in_acc <= arst_n && sample.valid && sample.ready;
		if (arst_n && sample.valid && sample.ready)
			drive_expect_q.push_back(steer_step(sample.opcode, sample.left_level,
				sample.right_level, sample.distance_cm));
	end

	always @(negedge clk) begin : feeder
		steer_req_t rq;
		if (arst_n && (!sample.valid || in_acc)) begin
			if (feed_gap != 0) begin
				sample.valid <= 1'b0;
				feed_gap <= feed_gap - 1;
			end else if (pend_q.size() != 0
					&& !(pend_q[0].hold && drive_expect_q.size() != 0)) begin
				rq = pend_q.pop_front();
				sample.valid       <= 1'b1;
				sample.opcode      <= rq.opcode;
				sample.left_level  <= rq.left_level;
				sample.right_level <= rq.right_level;
				sample.distance_cm <= rq.distance_cm;
				feed_gap <= pick_gap();
			end else begin
				// nothing to send, or a held request waits until every pending result has drained
				sample.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin : stall_gen
		int unsigned n;
		if (calm_left == 0) begin
			calm <= ~calm;
			calm_left <= calm ? $urandom_range(400, 100) : $urandom_range(80, 20);
		end else begin
			calm_left <= calm_left - 1;
		end
		if (stall_left != 0) begin
			drive.ready <= 1'b0;
			stall_left <= stall_left - 1;
		end else if ($urandom_range(3) == 0) begin
			n = pick_gap();
			drive.ready <= (n == 0);
			stall_left <= (n == 0) ? 0 : n - 1;
		end else begin
			drive.ready <= 1'b1;
		end
	end

	always @(posedge clk) begin : drive_mon
		drive_res_t want;
		if (arst_n && drive.valid && drive.ready) begin
			if (drive_expect_q.size() == 0) begin
				fail_cnt++;
				$display("%0t: unexpected result, expected none, actual mode %0d dodging %0d",
					$time, drive.drive_mode, drive.dodging);
			end else begin
				want = drive_expect_q.pop_front();
				check_field("drive_mode", int'(want.mode), int'(drive.drive_mode));
				check_field("motor_left", int'(want.motor_left), int'(drive.motor_left));
				check_field("motor_right", int'(want.motor_right), int'(drive.motor_right));
				check_field("dodging", int'(want.dodging), int'(drive.dodging));
			end
		end
	end

	initial begin
		#100_000_000;
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		int unsigned i;
		arst_n = 1'b0;
		sample.valid = 1'b0;
		sample.opcode = OP_SAMPLE;
		sample.left_level = '0;
		sample.right_level = '0;
		sample.distance_cm = '0;
		drive.ready = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		thr_r = LEVEL_BITS'(600);
		lim_r = DIST_BITS'(25);
		gp_r = GAIN_BITS'(4096);
		gi_r = GAIN_BITS'(410);
		gd_r = GAIN_BITS'(41);
		err_sum = '0;
		last_err = '0;
		dodge_on = 1'b0;
		dodge_ph = 0;
		ph_time = '0;
		drive_now = DRV_STOP;
		fail_cnt = 0;
		gen_dodge_left = 0;
		dodge_budget = 0;
		hold_next = 1'b0;
		in_acc = 1'b0;
		feed_gap = 0;
		stall_left = 0;
		calm = 1'b0;
		calm_left = 50;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset settings: line cases, threshold edge, obstacle just past the limit
		push_sample(700, 700, DIST_MAX);
		push_sample(LEVEL_MAX, 0, 100);
		push_sample(0, LEVEL_MAX, 100);
		push_sample(0, 0, DIST_MAX);
		push_tick();
		push_sample(800, 1000, 300);
		push_sample(1000, 700, 300);
		push_sample(600, 600, 26);
		push_sample(601, 601, 26);
		push_sample(LEVEL_MAX, LEVEL_MAX, 40);
		push_sample(512, 511, 26);
		push_sample(LEVEL_MAX, 0, 27);
		repeat (3) push_tick();
		push_sample(0, LEVEL_MAX, DIST_MAX);
		hold_next = 1'b1;
		run_random(250);

		// all zero: gains give no sign
		apply_settings(0, 0, 0, 0, 0);
		run_random(150);

		apply_settings($urandom_range(65535), $urandom_range(120), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(65535));
		run_random(200);

		// integral and derivative dominate the sign
		apply_settings($urandom_range(700, 500), 25, 16, 65535, 65535);
		run_random(200);

		apply_settings($urandom_range(65535), $urandom_range(120), $urandom_range(65535),
			$urandom_range(65535), $urandom_range(65535));
		run_random(150);

		// all ones: nothing reads black, every sample dodges; walk the first legs
		apply_settings(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
		push_tick();
		push_sample(pick_level(), pick_level(), DIST_MAX);
		for (i = 0; i < 850; i++)
			dodge_item();

		wait_idle();
		repeat (10) @(posedge clk);
		if (drive_expect_q.size() != 0) begin
			fail_cnt++;
			$display("%0t: results missing, expected %0d more, actual 0", $time,
				drive_expect_q.size());
		end
		if (fail_cnt == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
design/lfps_pkg.sv
design/lfps_sample_if.sv
design/lfps_drive_if.sv
design/lfps_cfg_if.sv
design/lfps_cfg_regs.sv
design/lfps_front.sv
design/lfps_back.sv
design/line_follower_pid_steering.sv
tb/sv/tb.sv
